@@ design/tsd_pkg.sv @@
// Package for the thermometer scratchpad decoder: frame constants, the
// record passed from the front end to the back end, and the CRC-8 helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tsd_pkg;

  localparam logic [3:0] FRAME_BYTES = 4'd9;
  localparam logic [3:0] POS_LOW     = 4'd0;
  localparam logic [3:0] POS_HIGH    = 4'd1;
  localparam logic [3:0] POS_CONFIG  = 4'd4;
  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] HALF_MARK   = 8'hFF;
  localparam int         QUEUE_DEPTH = 2;

  localparam logic [2:0] ROUND_TABLE [8] = '{3'd0, 3'd1, 3'd1, 3'd2,
                                             3'd3, 3'd3, 3'd4, 3'd4};

  typedef struct packed {
    logic       crc_bad;
    logic       half_mode;
    logic [7:0] low;
    logic [7:0] high;
  } frame_rec_t;

  // reflected CRC-8, one byte, LSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = data_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/thermometer_scratchpad_decoder.sv @@
// Top level of the thermometer scratchpad decoder: front end, record
// queue and back end. Depends on tsd_pkg, tsd_front, tsd_queue, tsd_back.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------
//   in      | in_valid/in_ready   | scratch_byte[7:0], frame_start
//   out     | out_valid/out_ready | temperature_tenths[11:0], status
//
// One byte per cycle while in_ready is high; the CRC byte update is
// combinational. A record goes via the queue to the output register.
// Reset clears position, CRC, captured bytes, queue and output valid.
// in_ready drops only while the two-entry record queue is full, which
// happens when the output register and both queue entries hold results.
`timescale 1ns / 1ps
`default_nettype none
module thermometer_scratchpad_decoder (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        scratch_byte,
  input  wire logic              frame_start,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [11:0]     temperature_tenths,
  output logic                   status
);
  import tsd_pkg::*;

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  frame_rec_t q_in;
  frame_rec_t q_head;

  tsd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .scratch_byte (scratch_byte),
    .frame_start  (frame_start),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  tsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tsd_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .temperature_tenths (temperature_tenths),
    .status             (status)
  );

endmodule
`default_nettype wire

@@ design/tsd_front.sv @@
// Front end: accepts scratchpad bytes, tracks position and CRC, captures
// the temperature bytes and format flag. Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        scratch_byte,
  input  wire logic              frame_start,
  input  wire logic              q_full,
  output logic                   q_push,
  output tsd_pkg::frame_rec_t    q_data
);
  import tsd_pkg::*;

  logic [7:0] crc_accum;
  logic [3:0] byte_position;
  logic [7:0] reading_low;
  logic [7:0] reading_high;
  logic       half_degree_mode;

  logic       take;
  logic       active;
  logic [3:0] pos_eff;
  logic [3:0] pos_next;
  logic [7:0] crc_next;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign pos_eff  = frame_start ? 4'd0 : byte_position;
  assign active   = frame_start || (byte_position < FRAME_BYTES);
  assign crc_next = crc8_update(frame_start ? 8'd0 : crc_accum, scratch_byte);
  assign pos_next = pos_eff + 4'd1;

  assign q_push           = take && active && (pos_next == FRAME_BYTES);
  assign q_data.crc_bad   = (crc_next != 8'd0);
  assign q_data.half_mode = half_degree_mode;
  assign q_data.low       = reading_low;
  assign q_data.high      = reading_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum        <= 8'd0;
      byte_position    <= 4'd0;
      reading_low      <= 8'd0;
      reading_high     <= 8'd0;
      half_degree_mode <= 1'b0;
    end else if (take && active) begin
      crc_accum     <= crc_next;
      byte_position <= pos_next;
      case (pos_eff)
        POS_LOW:    reading_low      <= scratch_byte;
        POS_HIGH:   reading_high     <= scratch_byte;
        POS_CONFIG: half_degree_mode <= (scratch_byte == HALF_MARK);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/tsd_queue.sv @@
// Small FIFO of finished-frame records between front and back ends.
// Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tsd_pkg::frame_rec_t push_data,
  input  wire logic              pop,
  output logic                   full,
  output logic                   not_empty,
  output tsd_pkg::frame_rec_t    head
);
  import tsd_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

  frame_rec_t          entries [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign full      = (count == DepthC);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/tsd_back.sv @@
// Back end: turns a frame record into tenths of a degree and a status,
// held in the output register. Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire tsd_pkg::frame_rec_t q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [11:0]     temperature_tenths,
  output logic                   status
);
  import tsd_pkg::*;

  logic [15:0]        raw;
  logic               neg;
  logic [15:0]        mag;
  logic [6:0]         whole;
  logic [10:0]        tenths_mag;
  logic [11:0]        half_count;
  logic [11:0]        half_tenths;
  logic [11:0]        frac_tenths;
  logic [11:0]        temp_calc;

  assign raw         = {q_head.high, q_head.low};
  assign neg         = raw[15];
  assign mag         = neg ? (16'd0 - raw) : raw;
  assign whole       = mag[10:4];
  assign tenths_mag  = {1'b0, whole, 3'b000} + {3'b000, whole, 1'b0}
                     + (mag[3] ? 11'd5 : 11'd0)
                     + {8'd0, ROUND_TABLE[mag[2:0]]};
  assign frac_tenths = neg ? (12'd0 - {1'b0, tenths_mag}) : {1'b0, tenths_mag};
  assign half_count  = {{4{q_head.high[7]}}, q_head.low};
  assign half_tenths = {half_count[9:0], 2'b00} + half_count;
  assign temp_calc   = q_head.crc_bad   ? 12'd0 :
                       q_head.half_mode ? half_tenths : frac_tenths;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      temperature_tenths <= signed'(temp_calc);
      status             <= q_head.crc_bad;
    end
  end

endmodule
`default_nettype wire

@@ design/tsd_checker.sv @@
// Port-level checks for the thermometer scratchpad decoder, bound to the
// top level. No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module tsd_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [11:0] temperature_tenths,
  input wire logic              status
);

  // a checksum error carries a zero temperature
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> temperature_tenths == 12'sd0)
    else $error("error result with nonzero temperature");

  // decoded temperature stays inside the sensor range
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> temperature_tenths >= -12'sd1280 && temperature_tenths <= 12'sd1279)
    else $error("temperature out of range");

  // nothing is offered right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature_tenths) && $stable(status))
    else $error("stalled result changed");

endmodule

bind thermometer_scratchpad_decoder tsd_checker u_tsd_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .temperature_tenths (temperature_tenths),
  .status             (status)
);
`default_nettype wire
